@@ design/hff_pkg.sv @@
// ----------------------------------------------------------------------------
// hff_pkg: shared types and constants of the hex field formatter
// Item structs, the field descriptor passed from front to back, and the
// character constants and digit encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package hff_pkg;

  localparam int unsigned MAX_FIELD = 64;
  localparam int unsigned CNT_W     = $clog2(MAX_FIELD + 1);
  localparam int unsigned ND_W      = 4;
  localparam int unsigned Q_DEPTH   = 2;
  localparam int unsigned Q_PTR_W   = $clog2(Q_DEPTH);
  localparam int unsigned Q_CNT_W   = $clog2(Q_DEPTH + 1);

  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_ZERO      = 8'h30;
  localparam logic [7:0] CH_NINE      = 8'h39;
  localparam logic [7:0] CH_UPPER_A   = 8'h41;
  localparam logic [7:0] CH_UPPER_F   = 8'h46;
  localparam logic [7:0] CH_LOWER_A   = 8'h61;
  localparam logic [7:0] CH_LOWER_F   = 8'h66;
  localparam logic [7:0] ALPHA_OFS    = 8'd87;
  localparam logic [7:0] CASE_OFS     = 8'd32;
  localparam logic [3:0] DEC_DIGITS   = 4'd10;

  typedef logic [CNT_W-1:0] cnt_t;

  typedef struct packed {
    logic [31:0] value;
    logic        upper_case;
    logic [6:0]  field_width;
    logic [6:0]  precision;
    logic        has_precision;
    logic        left_justify;
    logic        zero_pad;
  } in_item_t;

  typedef struct packed {
    logic [7:0] character;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic [31:0]     value;
    logic            upper_case;
    logic            left_justify;
    logic            pad_zero;
    cnt_t            pad;
    cnt_t            zeros;
    logic [ND_W-1:0] ndig;
  } desc_t;

  function automatic logic [7:0] digit_char(logic [3:0] nib, logic upper);
    logic [7:0] ch;
    if (nib < DEC_DIGITS) begin
      ch = CH_ZERO + 8'(nib);
    end else if (upper) begin
      ch = 8'(nib) + ALPHA_OFS - CASE_OFS;
    end else begin
      ch = 8'(nib) + ALPHA_OFS;
    end
    return ch;
  endfunction

endpackage

`default_nettype wire

@@ design/hex_field_formatter.sv @@
// ----------------------------------------------------------------------------
// hex_field_formatter: printf-style %x / %X field to ASCII characters
// Formats a 32-bit unsigned value with width, precision and flags and emits
// the field one character per output item, the final one marked by last.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_item_i) takes one field per
//   item. Output channel (out_valid_o / out_stall_i / out_item_o) gives one
//   character per item; last is set on the field's final character.
//   Path: the first character goes from the front classifier into the queue,
//   then into the sequencer's registers and from there into the output
//   register. Throughput: the sequencer sends one character per cycle
//   while the output is not stalled, so a field of 1 to MAX_FIELD
//   characters goes out and the next field follows with no gap. An empty
//   field is accepted and produces nothing.
//   The two-entry descriptor queue keeps taking items while the output is
//   stalled; in_stall_o rises only when it is full. A stalled output
//   character is held until taken.
//   Reset empties the queue and the output register; no item is pending.
// ----------------------------------------------------------------------------
`default_nettype none

module hex_field_formatter (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire hff_pkg::in_item_t in_item_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output hff_pkg::out_item_t     out_item_o
);

  logic           q_full, q_push, q_valid, q_pop;
  hff_pkg::desc_t push_desc, pop_desc;

  hff_front u_front (
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_desc_o   (push_desc)
  );

  hff_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_desc_i (push_desc),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .desc_o      (pop_desc)
  );

  hff_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_desc_i    (pop_desc),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  a_pop_needs_entry : assert property (
    @(posedge clk_i) disable iff (!rst_ni) q_pop |-> q_valid
  ) else $error("descriptor popped from empty queue");

  a_push_not_full : assert property (
    @(posedge clk_i) disable iff (!rst_ni) q_push |-> !q_full && in_valid_i
  ) else $error("descriptor pushed into full queue");

  a_char_legal : assert property (
    @(posedge clk_i) disable iff (!rst_ni) out_valid_o |->
      (out_item_o.character == hff_pkg::CH_SPACE) ||
      (out_item_o.character >= hff_pkg::CH_ZERO &&
       out_item_o.character <= hff_pkg::CH_NINE) ||
      (out_item_o.character >= hff_pkg::CH_UPPER_A &&
       out_item_o.character <= hff_pkg::CH_UPPER_F) ||
      (out_item_o.character >= hff_pkg::CH_LOWER_A &&
       out_item_o.character <= hff_pkg::CH_LOWER_F)
  ) else $error("character outside the hex field alphabet");

endmodule

`default_nettype wire

@@ design/hff_front.sv @@
// ----------------------------------------------------------------------------
// hff_front: input side of the hex field formatter
// Accepts an item, sizes its padding, zeros and digits, and pushes a field
// descriptor into the queue. Empty fields are dropped here.
// ----------------------------------------------------------------------------
`default_nettype none

module hff_front (
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire hff_pkg::in_item_t in_item_i,
  input  wire logic              q_full_i,
  output logic                   q_push_o,
  output hff_pkg::desc_t         q_desc_o
);

  logic [hff_pkg::ND_W-1:0] ndig;
  hff_pkg::cnt_t            width_c;
  hff_pkg::cnt_t            prec_c;
  hff_pkg::cnt_t            ndig_c;
  hff_pkg::cnt_t            zeros;
  hff_pkg::cnt_t            body;
  hff_pkg::cnt_t            pad;
  logic                     empty_field;

  always_comb begin
    ndig = hff_pkg::ND_W'(1);
    for (int i = 1; i < 8; i++) begin
      if (in_item_i.value[4*i +: 4] != 4'd0) begin
        ndig = hff_pkg::ND_W'(i + 1);
      end
    end
    if (in_item_i.value == 32'd0 && in_item_i.has_precision &&
        in_item_i.precision == 7'd0) begin
      ndig = '0;
    end

    width_c = (in_item_i.field_width > 7'(hff_pkg::MAX_FIELD)) ?
              hff_pkg::CNT_W'(hff_pkg::MAX_FIELD) :
              hff_pkg::CNT_W'(in_item_i.field_width);
    prec_c  = (in_item_i.precision > 7'(hff_pkg::MAX_FIELD)) ?
              hff_pkg::CNT_W'(hff_pkg::MAX_FIELD) :
              hff_pkg::CNT_W'(in_item_i.precision);
    if (!in_item_i.has_precision) begin
      prec_c = '0;
    end

    ndig_c = hff_pkg::CNT_W'(ndig);
    zeros  = (prec_c > ndig_c) ? prec_c - ndig_c : '0;
    body   = zeros + ndig_c;
    pad    = (width_c > body) ? width_c - body : '0;
    empty_field = (pad == '0) && (body == '0);
  end

  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i && !empty_field;

  always_comb begin
    q_desc_o.value        = in_item_i.value;
    q_desc_o.upper_case   = in_item_i.upper_case;
    q_desc_o.left_justify = in_item_i.left_justify;
    q_desc_o.pad_zero     = in_item_i.zero_pad && !in_item_i.has_precision &&
                            !in_item_i.left_justify;
    q_desc_o.pad          = pad;
    q_desc_o.zeros        = zeros;
    q_desc_o.ndig         = ndig;
  end

endmodule

`default_nettype wire

@@ design/hff_queue.sv @@
// ----------------------------------------------------------------------------
// hff_queue: descriptor queue between front and back
// Small register FIFO that lets the input and output sides stall apart.
// ----------------------------------------------------------------------------
`default_nettype none

module hff_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire hff_pkg::desc_t push_desc_i,
  output logic                full_o,
  input  wire logic           pop_i,
  output logic                valid_o,
  output hff_pkg::desc_t      desc_o
);

  hff_pkg::desc_t                mem_q [hff_pkg::Q_DEPTH];
  logic [hff_pkg::Q_PTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [hff_pkg::Q_PTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [hff_pkg::Q_CNT_W-1:0]   count_q, count_d;
  logic                          do_pop;

  assign full_o  = (count_q == hff_pkg::Q_CNT_W'(hff_pkg::Q_DEPTH));
  assign valid_o = (count_q != '0);
  assign desc_o  = mem_q[rd_ptr_q];
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == hff_pkg::Q_PTR_W'(hff_pkg::Q_DEPTH - 1)) ?
                 '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == hff_pkg::Q_PTR_W'(hff_pkg::Q_DEPTH - 1)) ?
                 '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_desc_i;
    end
  end

endmodule

`default_nettype wire

@@ design/hff_back.sv @@
// ----------------------------------------------------------------------------
// hff_back: character sequencer of the hex field formatter
// Walks a field descriptor through padding, zeros, digits and right padding,
// one character per unstalled cycle, into a registered output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module hff_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           q_valid_i,
  input  wire hff_pkg::desc_t q_desc_i,
  output logic                q_pop_o,
  output logic                out_valid_o,
  input  wire logic           out_stall_i,
  output hff_pkg::out_item_t  out_item_o
);

  localparam int unsigned REM_W = hff_pkg::CNT_W + 1;

  logic                     active_q, active_d;
  logic                     out_valid_q, out_valid_d;
  hff_pkg::out_item_t       out_q;
  logic [31:0]              value_q;
  logic                     upper_q, left_q, pad_zero_q;
  hff_pkg::cnt_t            pad_q, pad_d;
  hff_pkg::cnt_t            zeros_q, zeros_d;
  logic [hff_pkg::ND_W-1:0] ndig_q, ndig_d;

  logic                     advance, load, cur_last;
  logic [7:0]               cur_char;
  logic [2:0]               nib_idx;
  logic [REM_W-1:0]         remaining;

  assign nib_idx   = 3'(ndig_q - 1'b1);
  assign remaining = REM_W'(pad_q) + REM_W'(zeros_q) + REM_W'(ndig_q);
  assign cur_last  = (remaining == REM_W'(1));
  assign advance   = active_q && (!out_valid_q || !out_stall_i);
  assign load      = q_valid_i && (!active_q || (advance && cur_last));
  assign q_pop_o   = load;

  always_comb begin
    cur_char = hff_pkg::CH_SPACE;
    pad_d    = pad_q;
    zeros_d  = zeros_q;
    ndig_d   = ndig_q;
    if (!left_q && pad_q != '0) begin
      cur_char = pad_zero_q ? hff_pkg::CH_ZERO : hff_pkg::CH_SPACE;
      pad_d    = pad_q - 1'b1;
    end else if (zeros_q != '0) begin
      cur_char = hff_pkg::CH_ZERO;
      zeros_d  = zeros_q - 1'b1;
    end else if (ndig_q != '0) begin
      cur_char = hff_pkg::digit_char(value_q[{nib_idx, 2'b00} +: 4], upper_q);
      ndig_d   = ndig_q - 1'b1;
    end else begin
      cur_char = hff_pkg::CH_SPACE;
      pad_d    = pad_q - 1'b1;
    end
  end

  always_comb begin
    active_d    = active_q;
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
      active_d    = !cur_last;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (load) begin
      active_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      active_q    <= active_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q.character <= cur_char;
      out_q.last      <= cur_last;
      pad_q           <= pad_d;
      zeros_q         <= zeros_d;
      ndig_q          <= ndig_d;
    end
    if (load) begin
      value_q    <= q_desc_i.value;
      upper_q    <= q_desc_i.upper_case;
      left_q     <= q_desc_i.left_justify;
      pad_zero_q <= q_desc_i.pad_zero;
      pad_q      <= q_desc_i.pad;
      zeros_q    <= q_desc_i.zeros;
      ndig_q     <= q_desc_i.ndig;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

`default_nettype wire

@@ tb/hex_field_formatter_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hex_field_formatter_tb: self-checking bench for the hex field formatter
// Sends a short table of directed fields, some with typed expected text, then
// random fields, predicting the rest. Every output item is checked against
// the oldest expected character, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------

module hex_field_formatter_tb;

  localparam int unsigned IDLE_LIMIT = 2000;
  localparam int unsigned RANDOM_FIELDS = 100;
  localparam int unsigned DRAIN_CYCLES = 20;

  typedef byte unsigned char_q_t[$];

  typedef struct {
    hff_pkg::in_item_t item;
    bit                typed;
    string             text;
  } row_t;

  logic               clk;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  hff_pkg::in_item_t  in_item_i;
  logic               out_valid_o;
  logic               out_stall_i;
  hff_pkg::out_item_t out_item_o;

  hff_pkg::out_item_t pending_chars[$];
  row_t               plan[$];
  int unsigned        chars_checked = 0;
  int unsigned        mismatches = 0;
  int unsigned        fields_sent = 0;
  int unsigned        empty_fields = 0;
  int unsigned        longest_field = 0;
  int unsigned        idle_cycles = 0;
  int unsigned        taken_seen = 0;
  int unsigned        stall_left = 0;
  bit                 no_idle = 0;

  hex_field_formatter dut (
    .clk_i       (clk),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic hff_pkg::in_item_t make_field(logic [31:0] v, int up, int w, int p,
                                                   int hp, int lj, int zp);
    hff_pkg::in_item_t f;
    f.value         = v;
    f.upper_case    = 1'(up);
    f.field_width   = 7'(w);
    f.precision     = 7'(p);
    f.has_precision = 1'(hp);
    f.left_justify  = 1'(lj);
    f.zero_pad      = 1'(zp);
    return f;
  endfunction

  function automatic char_q_t predict_field(hff_pkg::in_item_t f);
    char_q_t     chars;
    int unsigned width;
    int unsigned prec;
    int unsigned ndig;
    int unsigned zeros;
    int unsigned pad;
    logic [31:0] rest;
    logic [3:0]  nib;
    byte unsigned pad_ch;
    width = (f.field_width > hff_pkg::MAX_FIELD) ? hff_pkg::MAX_FIELD : f.field_width;
    prec  = (f.precision > hff_pkg::MAX_FIELD) ? hff_pkg::MAX_FIELD : f.precision;
    if (!f.has_precision) prec = 0;
    ndig = 1;
    rest = f.value >> 4;
    while (rest != 0) begin
      ndig++;
      rest = rest >> 4;
    end
    if (f.value == 0 && f.has_precision && prec == 0) ndig = 0;
    zeros = (prec > ndig) ? prec - ndig : 0;
    pad = (width > zeros + ndig) ? width - zeros - ndig : 0;
    pad_ch = (f.zero_pad && !f.has_precision && !f.left_justify) ?
             hff_pkg::CH_ZERO : hff_pkg::CH_SPACE;
    if (!f.left_justify) repeat (pad) chars.push_back(pad_ch);
    repeat (zeros) chars.push_back(hff_pkg::CH_ZERO);
    for (int i = ndig; i > 0; i--) begin
      nib = f.value[(i-1)*4 +: 4];
      if (nib < 10) chars.push_back(8'(hff_pkg::CH_ZERO + nib));
      else if (f.upper_case) chars.push_back(8'(hff_pkg::CH_UPPER_A + nib - 10));
      else chars.push_back(8'(hff_pkg::CH_LOWER_A + nib - 10));
    end
    if (f.left_justify) repeat (pad) chars.push_back(hff_pkg::CH_SPACE);
    return chars;
  endfunction

  function automatic char_q_t text_chars(string s);
    char_q_t chars;
    for (int i = 0; i < s.len(); i++) chars.push_back(s[i]);
    return chars;
  endfunction

  function automatic hff_pkg::in_item_t random_field();
    logic [31:0] v;
    int          w;
    int          p;
    case ($urandom_range(0, 3))
      0: v = 32'h0;
      1: v = $urandom;
      default: v = $urandom >> (4 * $urandom_range(1, 7));
    endcase
    w = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 12);
    p = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 10);
    return make_field(v, $urandom_range(0, 1), w, p, $urandom_range(0, 1),
                      $urandom_range(0, 1), $urandom_range(0, 1));
  endfunction

  function automatic void add_row(hff_pkg::in_item_t f, bit typed, string text);
    row_t r;
    r.item  = f;
    r.typed = typed;
    r.text  = text;
    plan.push_back(r);
  endfunction

  // enter and leave at a falling edge
  task automatic send_field(hff_pkg::in_item_t f, char_q_t chars, int gap);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= f;
    do @(posedge clk); while (in_stall_o);
    foreach (chars[i]) begin
      pending_chars.push_back('{character: chars[i], last: (i == chars.size() - 1)});
    end
    fields_sent++;
    if (chars.size() == 0) empty_fields++;
    if (chars.size() > longest_field) longest_field = chars.size();
    @(negedge clk);
  endtask

  task automatic hold_until_drained();
    in_valid_i <= 1'b0;
    @(negedge clk);
    while (pending_chars.size() != 0) @(negedge clk);
  endtask

  initial begin
    hff_pkg::in_item_t f;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_item_i   = '0;
    out_stall_i = 1'b0;

    add_row(make_field(32'h0, 0, 0, 0, 0, 0, 0), 1, "0");
    add_row(make_field(32'h0, 0, 0, 0, 1, 0, 0), 1, "");
    add_row(make_field(32'h0, 0, 5, 0, 1, 0, 0), 1, "     ");
    add_row(make_field(32'h0, 0, 3, 0, 1, 1, 1), 1, "   ");
    add_row(make_field(32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0), 1, "ffffffff");
    add_row(make_field(32'hFFFF_FFFF, 1, 0, 0, 0, 0, 0), 1, "FFFFFFFF");
    add_row(make_field(32'hABCD_EF12, 1, 12, 0, 0, 0, 1), 1, "0000ABCDEF12");
    add_row(make_field(32'h1234, 0, 8, 0, 0, 1, 0), 1, "1234    ");
    add_row(make_field(32'h1234, 0, 8, 0, 0, 1, 1), 1, "1234    ");
    add_row(make_field(32'h1F, 0, 10, 6, 1, 0, 1), 1, "    00001f");
    add_row(make_field(32'h8000_0000, 0, 0, 127, 0, 0, 0), 1, "80000000");
    add_row(make_field(32'h9, 0, 3, 0, 0, 0, 1), 1, "009");
    add_row(make_field(32'hA, 0, 0, 0, 1, 0, 0), 1, "a");
    add_row(make_field(32'h0, 0, 0, 1, 1, 0, 0), 1, "0");
    add_row(make_field(32'h7, 0, 127, 0, 0, 0, 1), 0, "");
    add_row(make_field(32'h7, 1, 0, 127, 1, 0, 0), 0, "");
    add_row(make_field(32'hC0FF_EE00, 0, 64, 64, 1, 1, 1), 0, "");
    add_row(make_field(32'h5A5A_5A5A, 1, 100, 65, 1, 1, 1), 0, "");
    add_row(make_field(32'h0123_4567, 1, 20, 12, 1, 0, 0), 0, "");
    add_row(make_field(32'h89AB_CDEF, 0, 63, 9, 1, 1, 0), 0, "");

    repeat (7) @(negedge clk);
    rst_ni <= 1'b1;
    @(negedge clk);

    foreach (plan[i]) begin
      send_field(plan[i].item,
                 plan[i].typed ? text_chars(plan[i].text) : predict_field(plan[i].item),
                 $urandom_range(0, 19));
    end
    hold_until_drained();

    for (int n = 0; n < RANDOM_FIELDS; n++) begin
      if (n == RANDOM_FIELDS / 2) hold_until_drained();
      no_idle = ((n / 20) % 3 == 1);
      f = random_field();
      send_field(f, predict_field(f), no_idle ? 0 : $urandom_range(0, 19));
    end
    no_idle = 0;

    hold_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d fields (%0d empty, longest %0d chars), checked %0d chars",
             fields_sent, empty_fields, longest_field, chars_checked);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  always @(posedge clk) begin
    hff_pkg::out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      chars_checked++;
      if (pending_chars.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected char, expected none, actual %02h last %0b",
                 $time, out_item_o.character, out_item_o.last);
      end else begin
        want = pending_chars.pop_front();
        if (out_item_o.character !== want.character) begin
          mismatches++;
          $display("%0t: character mismatch, expected %02h, actual %02h",
                   $time, want.character, out_item_o.character);
        end
        if (out_item_o.last !== want.last) begin
          mismatches++;
          $display("%0t: last mismatch, expected %0b, actual %0b",
                   $time, want.last, out_item_o.last);
        end
      end
    end
  end

  always @(negedge clk) begin
    if (chars_checked != taken_seen) begin
      taken_seen = chars_checked;
      stall_left = no_idle ? 0 : $urandom_range(0, 19);
    end
    if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left--;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no item moved for %0d cycles, %0d chars still expected",
               $time, IDLE_LIMIT, pending_chars.size());
      $display("== FAIL ==");
      $finish;
    end
  end

endmodule
